/* rtl/core/itoa_fmt_pkg.sv */
// ----------------------------------------------------------------------------
// itoa_fmt_pkg
// Shared types, constants and helpers of the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package itoa_fmt_pkg;

   // Field limits
   localparam int MAX_WIDTH    = 64;
   localparam int DIGIT_BUFFER = 32;
   localparam int MD_MAX       = DIGIT_BUFFER - 2;

   // Payload widths
   localparam int KIND_W  = 2;
   localparam int VALUE_W = 32;
   localparam int FW_W    = 7;
   localparam int MD_W    = 5;
   localparam int CHAR_W  = 8;

   // Internal widths
   localparam int DEC_DIGITS = 10;
   localparam int DIG_IDX_W  = $clog2(DEC_DIGITS);
   localparam int CNT_W      = $clog2(DEC_DIGITS + 1);
   localparam int BCD_W      = 4 * DEC_DIGITS;
   localparam int CONV_W     = $clog2(VALUE_W);
   localparam int TXT_W      = $clog2(DIGIT_BUFFER);
   localparam int N_W        = TXT_W + 1;
   localparam int KPOS_W     = $clog2(MAX_WIDTH);
   localparam int EMIT_W     = $clog2(MAX_WIDTH + 1);

   // Conversion codes
   typedef enum logic [KIND_W-1:0] {
      KIND_DEC    = 2'd0,
      KIND_HEX_LO = 2'd1,
      KIND_HEX_UP = 2'd2,
      KIND_CHAR   = 2'd3
   } kind_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIZE,
      ST_PLACE,
      ST_EMIT
   } state_type;

   // Characters
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
   localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
   localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
   localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;

   // Request payload as seen by the datapath
   typedef struct packed {
      kind_type           kind;
      logic [VALUE_W-1:0] value;
      logic [FW_W-1:0]    min_width;
      logic [MD_W-1:0]    min_digits;
      logic               left_align;
      logic               zero_fill;
      logic               force_plus;
      logic               hex_prefix;
   } req_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic conv_step;
      logic size;
      logic place;
      logic emit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic conv_done;
      logic out_free;
      logic last_char;
   } sts_type;

   // One hex or decimal digit as ASCII
   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
      logic [CHAR_W-1:0] base;
      base = upper ? CH_A_UP : CH_A_LO;
      if (d < 4'd10)
         digit_char = CH_ZERO + CHAR_W'(d);
      else
         digit_char = base + CHAR_W'(d - 4'd10);
   endfunction

endpackage

/* rtl/core/itoa_fmt_req_if.sv */
// ----------------------------------------------------------------------------
// itoa_fmt_req_if
// Request channel: one conversion with its formatting options.
// ----------------------------------------------------------------------------
interface itoa_fmt_req_if import itoa_fmt_pkg::*;;
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [VALUE_W-1:0] value;
   logic [FW_W-1:0]    min_width;
   logic [MD_W-1:0]    min_digits;
   logic               left_align;
   logic               zero_fill;
   logic               force_plus;
   logic               hex_prefix;

   modport source (
      output valid, kind, value, min_width, min_digits,
             left_align, zero_fill, force_plus, hex_prefix,
      input  ready
   );
   modport sink (
      input  valid, kind, value, min_width, min_digits,
             left_align, zero_fill, force_plus, hex_prefix,
      output ready
   );
endinterface

/* rtl/core/itoa_fmt_rsp_if.sv */
// ----------------------------------------------------------------------------
// itoa_fmt_rsp_if
// Response channel: one formatted character per transfer.
// ----------------------------------------------------------------------------
interface itoa_fmt_rsp_if import itoa_fmt_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] out_char;
   logic              last;

   modport source (
      output valid, out_char, last,
      input  ready
   );
   modport sink (
      input  valid, out_char, last,
      output ready
   );
endinterface

/* rtl/core/itoa_fmt_ctrl.sv */
// ----------------------------------------------------------------------------
// itoa_fmt_ctrl
// Sequencer: accept, convert, size, place, then stream the field out.
// ----------------------------------------------------------------------------
module itoa_fmt_ctrl import itoa_fmt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid)
               state_in = ST_CONV;
         end
         ST_CONV: begin
            if (sts.conv_done)
               state_in = ST_SIZE;
         end
         ST_SIZE:  state_in = ST_PLACE;
         ST_PLACE: state_in = ST_EMIT;
         ST_EMIT: begin
            if (sts.out_free && sts.last_char)
               state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CONV:  cmd.conv_step = 1'b1;
         ST_SIZE:  cmd.size      = 1'b1;
         ST_PLACE: cmd.place     = 1'b1;
         ST_EMIT:  cmd.emit      = sts.out_free;
         default: ;
      endcase
   end

   // A stalled output keeps the sequencer in the emit phase
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !sts.out_free) |=> state_ff == ST_EMIT)
      else $error("emit phase left while output stalled");

   // Final character returns to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && sts.last_char) |=> state_ff == ST_IDLE)
      else $error("no return to idle after last character");

endmodule

/* rtl/core/itoa_fmt_dp.sv */
// ----------------------------------------------------------------------------
// itoa_fmt_dp
// Datapath: bit-serial binary to BCD, field geometry and character output.
// ----------------------------------------------------------------------------
module itoa_fmt_dp import itoa_fmt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  req_payload_type   req,
   input  cmd_type           cmd,
   output sts_type           sts,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CHAR_W-1:0] rsp_out_char,
   output logic              rsp_last
);

   // Captured request
   kind_type          kind_ff;
   logic              neg_ff;
   logic [FW_W-1:0]   fw_ff;
   logic [TXT_W-1:0]  md_ff;
   logic              left_ff;
   logic              zfill_ff;
   logic              plus_ff;
   logic              prefix_ff;

   // Conversion
   logic [VALUE_W-1:0] bin_ff;
   logic [BCD_W-1:0]   bcd_ff;
   logic [BCD_W-1:0]   bcd_adj;
   logic [CONV_W-1:0]  conv_cnt_ff;

   // Geometry
   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic [TXT_W-1:0]  nd_ff,   nd_in;
   logic [1:0]        plen_ff, plen_in;
   logic [N_W-1:0]    n_ff,    n_in;
   logic [FW_W-1:0]   span;
   logic [FW_W-1:0]   start_ff, end_ff;
   logic [EMIT_W-1:0] emit_ff;
   logic [KPOS_W-1:0] k_ff;

   // Output register
   logic              rsp_valid_ff;
   logic [CHAR_W-1:0] out_char_ff;
   logic              last_ff;

   logic              is_dec, is_char, is_upper;
   logic [FW_W-1:0]   kx;
   logic [TXT_W-1:0]  t, u, p;
   logic              in_text;
   logic [CHAR_W-1:0] txt_char, cur_char;
   logic              last_char;
   logic              bcd_ok;

   assign is_dec   = (kind_ff == KIND_DEC);
   assign is_char  = (kind_ff == KIND_CHAR);
   assign is_upper = (kind_ff == KIND_HEX_UP);

   // Request capture, magnitude and precision clamp
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= kind_type'(req.kind);
         neg_ff    <= (req.kind == KIND_DEC) && req.value[VALUE_W-1];
         fw_ff     <= req.min_width;
         md_ff     <= (req.min_digits > MD_W'(MD_MAX)) ? TXT_W'(MD_MAX)
                                                      : TXT_W'(req.min_digits);
         left_ff   <= req.left_align;
         zfill_ff  <= req.zero_fill;
         plus_ff   <= req.force_plus;
         prefix_ff <= req.hex_prefix;
      end
   end

   // Add-3 correction for every BCD digit
   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5)
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         else
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
      end
   end

   // Double dabble, one bit per cycle; hex and char load digits directly
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         conv_cnt_ff <= '0;
         if (req.kind == KIND_DEC) begin
            bin_ff <= req.value[VALUE_W-1] ? (VALUE_W'(0) - req.value) : req.value;
            bcd_ff <= '0;
         end else begin
            bin_ff <= '0;
            bcd_ff <= {{(BCD_W-VALUE_W){1'b0}}, req.value};
         end
      end else if (cmd.conv_step && is_dec) begin
         bcd_ff      <= {bcd_adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
         bin_ff      <= {bin_ff[VALUE_W-2:0], 1'b0};
         conv_cnt_ff <= conv_cnt_ff + CONV_W'(1);
      end
   end

   assign sts.conv_done = !is_dec || (conv_cnt_ff == CONV_W'(VALUE_W - 1));

   // Significant digit count, digits after precision, text length
   always_comb begin
      cnt_in = CNT_W'(1);
      for (int i = 1; i < DEC_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0)
            cnt_in = CNT_W'(i + 1);
      end
      nd_in = (TXT_W'(cnt_in) > md_ff) ? TXT_W'(cnt_in) : md_ff;
      if (is_dec)
         plen_in = (neg_ff || plus_ff) ? 2'd1 : 2'd0;
      else if (!is_char && prefix_ff)
         plen_in = 2'd2;
      else
         plen_in = 2'd0;
      n_in = is_char ? N_W'(1) : (N_W'(plen_in) + N_W'(nd_in));
   end

   always_ff @(posedge clock) begin
      if (cmd.size) begin
         cnt_ff  <= cnt_in;
         nd_ff   <= nd_in;
         plen_ff <= plen_in;
         n_ff    <= n_in;
      end
   end

   // Field span, text window and emitted count
   assign span = (fw_ff > FW_W'(n_ff)) ? fw_ff : FW_W'(n_ff);

   always_ff @(posedge clock) begin
      if (cmd.place) begin
         end_ff   <= left_ff ? FW_W'(n_ff) : span;
         start_ff <= left_ff ? '0 : (span - FW_W'(n_ff));
         emit_ff  <= (span > FW_W'(MAX_WIDTH)) ? EMIT_W'(MAX_WIDTH) : EMIT_W'(span);
         k_ff     <= '0;
      end else if (cmd.emit) begin
         k_ff <= k_ff + KPOS_W'(1);
      end
   end

   // Character at field position k
   assign kx      = {{(FW_W-KPOS_W){1'b0}}, k_ff};
   assign in_text = (kx >= start_ff) && (kx < end_ff);
   assign t       = TXT_W'(kx - start_ff);
   assign u       = t - TXT_W'(plen_ff);
   assign p       = nd_ff - TXT_W'(1) - u;

   always_comb begin
      if (is_char)
         txt_char = bcd_ff[CHAR_W-1:0];
      else if (t < TXT_W'(plen_ff)) begin
         if (is_dec)
            txt_char = neg_ff ? CH_MINUS : CH_PLUS;
         else if (t == '0)
            txt_char = CH_ZERO;
         else
            txt_char = is_upper ? CH_X_UP : CH_X_LO;
      end else if (p < TXT_W'(cnt_ff))
         txt_char = digit_char(bcd_ff[4*p[DIG_IDX_W-1:0] +: 4], is_upper);
      else
         txt_char = CH_ZERO;
   end

   assign cur_char  = in_text ? txt_char : (zfill_ff ? CH_ZERO : CH_SPACE);
   assign last_char = ({1'b0, k_ff} == (emit_ff - EMIT_W'(1)));

   // Output register
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;
   assign sts.last_char = last_char;

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.emit)
         rsp_valid_ff <= 1'b1;
      else if (rsp_ready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_char_ff <= cur_char;
         last_ff     <= last_char;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_last     = last_ff;

   // Every BCD digit in range once conversion is over
   always_comb begin
      bcd_ok = 1'b1;
      for (int i = 0; i < DEC_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] > 4'd9)
            bcd_ok = 1'b0;
      end
   end

   a_bcd_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.size && is_dec) |-> bcd_ok)
      else $error("BCD digit out of range after conversion");

   a_pos_in_field: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> ({1'b0, k_ff} < emit_ff))
      else $error("character position past end of field");

   a_field_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (emit_ff != '0) && (n_ff != '0))
      else $error("empty field");

endmodule

/* rtl/core/integer_to_ascii_formatter_unit.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Formats one printf integer or character conversion into ASCII characters.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one conversion (kind, value, width, precision and flags);
//   it is taken when valid and ready are high together. rsp_ch returns the
//   formatted field one character per transfer, with last set on the final
//   character. Every conversion yields at least one character, at most
//   MAX_WIDTH.
// Flow:
//   A decimal value passes through a bit-serial binary to BCD converter,
//   one bit per cycle; hex and character conversions skip it. The field is
//   then sized and placed, and streamed out one character per cycle while
//   rsp_ch.ready does not stall the output register.
//   A new request is taken once the previous field's last character sits in
//   the output register.
// Reset and stalls:
//   Synchronous reset returns to idle and drops any pending character.
//   When rsp_ch.ready is low the character waits in the output register and
//   the field position holds.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit import itoa_fmt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   itoa_fmt_req_if.sink     req_ch,
   itoa_fmt_rsp_if.source   rsp_ch
);

   cmd_type         cmd;
   sts_type         sts;
   req_payload_type req_payload;

   // Request payload bundle
   always_comb begin
      req_payload.kind        = kind_type'(req_ch.kind);
      req_payload.value       = req_ch.value;
      req_payload.min_width   = req_ch.min_width;
      req_payload.min_digits  = req_ch.min_digits;
      req_payload.left_align  = req_ch.left_align;
      req_payload.zero_fill   = req_ch.zero_fill;
      req_payload.force_plus  = req_ch.force_plus;
      req_payload.hex_prefix  = req_ch.hex_prefix;
   end

   itoa_fmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   itoa_fmt_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .req          (req_payload),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .rsp_out_char (rsp_ch.out_char),
      .rsp_last     (rsp_ch.last)
   );

endmodule
